// File: rtl/jfp_pkg.sv
// jfp_pkg: shared types and constants for the fuse file parser
// parse states, error codes, character codes and the result record
// no dependencies
package jfp_pkg;

  localparam int unsigned FUSE_ADDR_BITS = 20;
  localparam int unsigned PIN_BITS       = 16;
  localparam int unsigned CSUM_BITS      = 16;
  localparam int unsigned OUT_ADDR_BITS  = 20;

  typedef enum logic [3:0] {
    ST_WAIT  = 4'd0,
    ST_BASE  = 4'd1,
    ST_CSUM  = 4'd2,
    ST_LADDR = 4'd3,
    ST_LBITS = 4'd4,
    ST_Q     = 4'd5,
    ST_QF    = 4'd6,
    ST_QP    = 4'd7,
    ST_SKIP  = 4'd8,
    ST_HALT  = 4'd9
  } parse_state_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_LADDR    = 3'd1,
    ERR_FUSE     = 3'd2,
    ERR_CSUM     = 3'd3,
    ERR_COUNT    = 3'd4,
    ERR_REPEAT   = 3'd5,
    ERR_RANGE    = 3'd6,
    ERR_OVERFLOW = 3'd7
  } err_code_t;

  localparam logic [7:0] CH_STX    = 8'h02;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_L      = 8'h4c;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_Q      = 8'h51;
  localparam logic [7:0] UPPER_MASK = 8'h5f;

  typedef struct packed {
    logic                      fuse_write;
    logic [OUT_ADDR_BITS-1:0]  fuse_address;
    logic                      fuse_value;
    logic [OUT_ADDR_BITS-1:0]  fuse_total;
    logic [PIN_BITS-1:0]       pin_total;
    logic [CSUM_BITS-1:0]      declared_checksum;
    err_code_t                 error_code;
    logic                      halted;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_slot_t;

endpackage

// File: rtl/jedec_fuse_file_parser_unit.sv
// jedec_fuse_file_parser_unit: top level of the fuse file parser
// byte input register, parse core with result register; depends on jfp_pkg,
// jfp_in_stage and jfp_core
//
// usage
//   in_*  : one text byte per transfer of the fuse file
//   out_* : exactly one result per input byte, in order
//   the parser waits for STX, then reads QF/QP counts, L fuse runs and the
//   C checksum; each in-range 0/1 in an L run gives a result with out_tuser set
// datapath and throughput
//   a transferred byte is held in the input register and decoded from it; its
//   result is captured in the result register, which drives out_*
//   one byte per cycle sustained while out_tready is high; the whole state
//   update for a byte is a single pass of logic between the two registers
// reset
//   synchronous rst_n clears the parse state, counts, checksum and error;
//   the input and result registers come up empty
// stall
//   with out_tready low the result register holds and the input register
//   takes one more byte, then in_tready drops until the result is taken
module jedec_fuse_file_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // byte_req
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // fuse_address, fuse_value, fuse_total, pin_total,
                                  // declared_checksum, error_code, halted, zero fill
  output logic        out_tuser   // fuse_write
);

  jfp_pkg::byte_slot_t slot;
  jfp_pkg::result_t    res;
  logic                take;

  jfp_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .slot      (slot),
    .take      (take)
  );

  jfp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .slot      (slot),
    .take      (take),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tuser = res.fuse_write;
  assign out_tdata = {3'd0, res.halted, res.error_code, res.declared_checksum,
                      res.pin_total, res.fuse_total, res.fuse_value, res.fuse_address};

endmodule

// File: rtl/jfp_in_stage.sv
// jfp_in_stage: input register for the byte stream
// holds one byte until the parse stage takes it; depends on jfp_pkg
module jfp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  output jfp_pkg::byte_slot_t slot,
  input  logic              take
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;

  assign in_tready = !valid_r || take;
  assign valid_nxt = (in_tvalid && in_tready) || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata;
    end
  end

  assign slot.valid = valid_r;
  assign slot.data  = data_r;

endmodule

// File: rtl/jfp_core.sv
// jfp_core: parse state, field accumulators and the result register
// one byte is decoded per cycle unless a held result blocks it; depends on jfp_pkg
module jfp_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  jfp_pkg::byte_slot_t   slot,
  output logic                  take,
  output logic                  res_valid,
  input  logic                  res_ready,
  output jfp_pkg::result_t      res
);

  localparam int unsigned AW = jfp_pkg::FUSE_ADDR_BITS;
  localparam int unsigned PW = jfp_pkg::PIN_BITS;
  localparam int unsigned CW = jfp_pkg::CSUM_BITS;

  jfp_pkg::parse_state_t state_r, state_nxt;
  jfp_pkg::err_code_t    err_r, err_nxt;
  logic [AW-1:0]         fuse_total_r, fuse_total_nxt;
  logic [AW-1:0]         fuse_ptr_r, fuse_ptr_nxt;
  logic [PW-1:0]         pin_total_r, pin_total_nxt;
  logic [CW-1:0]         csum_r, csum_nxt;
  logic                  res_valid_r;
  jfp_pkg::result_t      res_r;

  logic [7:0]    c;
  logic [7:0]    c_up;
  logic          is_ws, is_dig, is_hex_letter, is_bit, is_bit_ws;
  logic [3:0]    hex_nib;
  logic [AW+3:0] fp_dec, ft_dec;
  logic [PW+3:0] pt_dec;
  logic          fp_ovf, ft_ovf, pt_ovf, in_range;
  logic          wr;
  logic [AW-1:0] wr_addr;

  assign take = slot.valid && (!res_valid_r || res_ready);
  assign c    = slot.data;
  assign c_up = c & jfp_pkg::UPPER_MASK;

  assign is_ws  = (c == jfp_pkg::CH_SPACE) || (c >= jfp_pkg::CH_TAB && c <= jfp_pkg::CH_CR);
  assign is_dig = (c >= jfp_pkg::CH_ZERO) && (c <= jfp_pkg::CH_NINE);
  assign is_hex_letter = (c_up >= jfp_pkg::CH_A) && (c_up <= jfp_pkg::CH_F);
  assign is_bit = (c == jfp_pkg::CH_ZERO) || (c == jfp_pkg::CH_ONE);
  assign is_bit_ws = (c == jfp_pkg::CH_SPACE) || (c == jfp_pkg::CH_LF) ||
                     (c == jfp_pkg::CH_CR);
  assign hex_nib = is_dig ? c[3:0] : 4'(c_up - jfp_pkg::CH_SEVEN);

  // value * 10 + digit as two shifts and two adds
  assign fp_dec = ({4'd0, fuse_ptr_r} << 3) + ({4'd0, fuse_ptr_r} << 1) + (AW+4)'(c[3:0]);
  assign ft_dec = ({4'd0, fuse_total_r} << 3) + ({4'd0, fuse_total_r} << 1) +
                  (AW+4)'(c[3:0]);
  assign pt_dec = ({4'd0, pin_total_r} << 3) + ({4'd0, pin_total_r} << 1) +
                  (PW+4)'(c[3:0]);
  assign fp_ovf = |fp_dec[AW+3:AW];
  assign ft_ovf = |ft_dec[AW+3:AW];
  assign pt_ovf = |pt_dec[PW+3:PW];
  assign in_range = fuse_ptr_r < fuse_total_r;

  // next state and error code
  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    unique case (state_r)
      jfp_pkg::ST_WAIT: begin
        if (c == jfp_pkg::CH_STX) state_nxt = jfp_pkg::ST_BASE;
      end
      jfp_pkg::ST_BASE: begin
        if (!is_ws) begin
          if (c == jfp_pkg::CH_L)      state_nxt = jfp_pkg::ST_LADDR;
          else if (c == jfp_pkg::CH_Q) state_nxt = jfp_pkg::ST_Q;
          else if (c == jfp_pkg::CH_C) state_nxt = jfp_pkg::ST_CSUM;
          else                         state_nxt = jfp_pkg::ST_SKIP;
        end
      end
      jfp_pkg::ST_CSUM: begin
        if (!is_ws) begin
          if (c == jfp_pkg::CH_STAR) begin
            state_nxt = jfp_pkg::ST_BASE;
          end else if (!is_dig && !is_hex_letter) begin
            state_nxt = jfp_pkg::ST_HALT;
            err_nxt   = jfp_pkg::ERR_CSUM;
          end
        end
      end
      jfp_pkg::ST_LADDR: begin
        if (is_dig) begin
          if (fp_ovf) begin
            state_nxt = jfp_pkg::ST_HALT;
            err_nxt   = jfp_pkg::ERR_OVERFLOW;
          end
        end else if (is_ws) begin
          state_nxt = jfp_pkg::ST_LBITS;
        end else if (c == jfp_pkg::CH_STAR) begin
          state_nxt = jfp_pkg::ST_BASE;
        end else begin
          state_nxt = jfp_pkg::ST_HALT;
          err_nxt   = jfp_pkg::ERR_LADDR;
        end
      end
      jfp_pkg::ST_LBITS: begin
        if (c == jfp_pkg::CH_STAR) begin
          state_nxt = jfp_pkg::ST_BASE;
        end else if (is_bit) begin
          if (!in_range) begin
            state_nxt = jfp_pkg::ST_HALT;
            err_nxt   = jfp_pkg::ERR_RANGE;
          end
        end else if (!is_bit_ws) begin
          state_nxt = jfp_pkg::ST_HALT;
          err_nxt   = jfp_pkg::ERR_FUSE;
        end
      end
      jfp_pkg::ST_Q: begin
        if (c == jfp_pkg::CH_F) begin
          if (fuse_total_r != '0) begin
            state_nxt = jfp_pkg::ST_HALT;
            err_nxt   = jfp_pkg::ERR_REPEAT;
          end else begin
            state_nxt = jfp_pkg::ST_QF;
          end
        end else if (c == jfp_pkg::CH_P) begin
          if (pin_total_r != '0) begin
            state_nxt = jfp_pkg::ST_HALT;
            err_nxt   = jfp_pkg::ERR_REPEAT;
          end else begin
            state_nxt = jfp_pkg::ST_QP;
          end
        end else begin
          state_nxt = jfp_pkg::ST_SKIP;
        end
      end
      jfp_pkg::ST_QF, jfp_pkg::ST_QP: begin
        if (!is_ws) begin
          if (is_dig) begin
            if ((state_r == jfp_pkg::ST_QF) ? ft_ovf : pt_ovf) begin
              state_nxt = jfp_pkg::ST_HALT;
              err_nxt   = jfp_pkg::ERR_OVERFLOW;
            end
          end else if (c == jfp_pkg::CH_STAR) begin
            state_nxt = jfp_pkg::ST_BASE;
          end else begin
            state_nxt = jfp_pkg::ST_HALT;
            err_nxt   = jfp_pkg::ERR_COUNT;
          end
        end
      end
      jfp_pkg::ST_SKIP: begin
        if (c == jfp_pkg::CH_STAR) state_nxt = jfp_pkg::ST_BASE;
      end
      jfp_pkg::ST_HALT: begin
        state_nxt = jfp_pkg::ST_HALT;
      end
      default: begin
        state_nxt = jfp_pkg::ST_HALT;
      end
    endcase
  end

  // accumulators and fuse write
  always_comb begin
    fuse_total_nxt = fuse_total_r;
    fuse_ptr_nxt   = fuse_ptr_r;
    pin_total_nxt  = pin_total_r;
    csum_nxt       = csum_r;
    wr             = 1'b0;
    wr_addr        = '0;
    unique case (state_r)
      jfp_pkg::ST_BASE: begin
        if (!is_ws && c == jfp_pkg::CH_L) fuse_ptr_nxt = '0;
        if (!is_ws && c == jfp_pkg::CH_C) csum_nxt = '0;
      end
      jfp_pkg::ST_CSUM: begin
        if (!is_ws && (is_dig || is_hex_letter)) csum_nxt = {csum_r[CW-5:0], hex_nib};
      end
      jfp_pkg::ST_LADDR: begin
        if (is_dig && !fp_ovf) fuse_ptr_nxt = fp_dec[AW-1:0];
      end
      jfp_pkg::ST_LBITS: begin
        if (is_bit && in_range) begin
          wr           = 1'b1;
          wr_addr      = fuse_ptr_r;
          fuse_ptr_nxt = fuse_ptr_r + AW'(1);
        end
      end
      jfp_pkg::ST_QF: begin
        if (is_dig && !ft_ovf) fuse_total_nxt = ft_dec[AW-1:0];
      end
      jfp_pkg::ST_QP: begin
        if (is_dig && !pt_ovf) pin_total_nxt = pt_dec[PW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= jfp_pkg::ST_WAIT;
      err_r        <= jfp_pkg::ERR_NONE;
      fuse_total_r <= '0;
      fuse_ptr_r   <= '0;
      pin_total_r  <= '0;
      csum_r       <= '0;
      res_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        state_r      <= state_nxt;
        err_r        <= err_nxt;
        fuse_total_r <= fuse_total_nxt;
        fuse_ptr_r   <= fuse_ptr_nxt;
        pin_total_r  <= pin_total_nxt;
        csum_r       <= csum_nxt;
      end
      if (take) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r.fuse_write        <= wr;
      res_r.fuse_address      <= jfp_pkg::OUT_ADDR_BITS'(wr_addr);
      res_r.fuse_value        <= wr & c[0];
      res_r.fuse_total        <= jfp_pkg::OUT_ADDR_BITS'(fuse_total_nxt);
      res_r.pin_total         <= pin_total_nxt;
      res_r.declared_checksum <= csum_nxt;
      res_r.error_code        <= err_nxt;
      res_r.halted            <= (state_nxt == jfp_pkg::ST_HALT);
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// File: sim/tb_jedec_fuse_file_parser_unit.sv
// tb_jedec_fuse_file_parser_unit: self-checking bench for the fuse file parser
// streams fuse file text with random gaps and stalls, predicts every result
// record in order and ends on one sticky error; depends on jfp_pkg and the rtl
`timescale 1ns / 100ps

module tb_jedec_fuse_file_parser_unit;

  localparam int unsigned FUSE_TOP     = 1048575;
  localparam int unsigned RANDOM_BYTES = 1640;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_GAP      = 12;
  localparam logic [63:0] ADDR_MAX     = (64'd1 << jfp_pkg::FUSE_ADDR_BITS) - 64'd1;
  localparam logic [63:0] PIN_MAX      = 64'h0000_0000_0000_ffff;
  localparam logic [7:0]  CH_VT        = 8'h0b;
  localparam logic [7:0]  CH_FF        = 8'h0c;

  typedef enum int {
    END_LADDR_CHAR,
    END_FUSE_CHAR,
    END_CSUM_CHAR,
    END_COUNT_CHAR,
    END_REPEAT,
    END_RANGE,
    END_ADDR_OVERFLOW,
    END_PIN_OVERFLOW
  } finale_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;   // fuse_address, fuse_value, fuse_total, pin_total,
                            // declared_checksum, error_code, halted, zero fill
  logic        out_tuser;   // fuse_write

  // parser state mirror
  jfp_pkg::parse_state_t              p_state = jfp_pkg::ST_WAIT;
  logic [jfp_pkg::FUSE_ADDR_BITS-1:0] fuse_limit = '0;
  logic [jfp_pkg::FUSE_ADDR_BITS-1:0] fuse_at = '0;
  logic [jfp_pkg::PIN_BITS-1:0]       pin_limit = '0;
  logic [jfp_pkg::CSUM_BITS-1:0]      csum_acc = '0;
  jfp_pkg::err_code_t                 err_seen = jfp_pkg::ERR_NONE;

  jfp_pkg::result_t pending_results[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned sent_count = 0;
  int unsigned sink_hold = 0;
  int unsigned sink_gap;
  bit          src_quiet = 1'b0;
  bit          sink_quiet = 1'b0;
  finale_t     final_kind;
  bit          pins_used;

  jedec_fuse_file_parser_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_jedec_fuse_file_parser_unit failed");
    $finish;
  end

  function automatic bit is_space(input logic [7:0] c);
    return c == jfp_pkg::CH_SPACE || (c >= jfp_pkg::CH_TAB && c <= jfp_pkg::CH_CR);
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= jfp_pkg::CH_ZERO && c <= jfp_pkg::CH_NINE;
  endfunction

  function automatic logic [63:0] decimal_step(input logic [63:0] v, input logic [7:0] c);
    return v * 64'd10 + 64'(c - jfp_pkg::CH_ZERO);
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(0, 5))
      0: return jfp_pkg::CH_SPACE;
      1: return jfp_pkg::CH_TAB;
      2: return jfp_pkg::CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return jfp_pkg::CH_CR;
    endcase
  endfunction

  // lower case and bit 7 variants reduce to the same hex letter
  function automatic logic [7:0] hex_char();
    int unsigned k;
    logic [7:0]  pick;
    k = $urandom_range(0, 15);
    if (k < 10) begin
      pick = jfp_pkg::CH_ZERO + 8'(k);
    end else begin
      pick = jfp_pkg::CH_A + 8'(k - 10);
      case ($urandom_range(0, 3))
        0: pick = pick;
        1: pick = pick | 8'h20;
        2: pick = pick | 8'h80;
        default: pick = pick | 8'ha0;
      endcase
    end
    return pick;
  endfunction

  task automatic halt_on(input jfp_pkg::err_code_t code);
    err_seen = code;
    p_state  = jfp_pkg::ST_HALT;
  endtask

  // expected result of one accepted byte
  task automatic parse_byte(input logic [7:0] c);
    jfp_pkg::result_t r;
    logic [63:0]      n;
    logic [7:0]       u;
    r = '0;
    u = c & jfp_pkg::UPPER_MASK;
    case (p_state)
      jfp_pkg::ST_WAIT: begin
        if (c == jfp_pkg::CH_STX) p_state = jfp_pkg::ST_BASE;
      end
      jfp_pkg::ST_BASE: begin
        if (!is_space(c)) begin
          if (c == jfp_pkg::CH_L) begin
            p_state = jfp_pkg::ST_LADDR;
            fuse_at = '0;
          end else if (c == jfp_pkg::CH_Q) begin
            p_state = jfp_pkg::ST_Q;
          end else if (c == jfp_pkg::CH_C) begin
            p_state  = jfp_pkg::ST_CSUM;
            csum_acc = '0;
          end else begin
            p_state = jfp_pkg::ST_SKIP;
          end
        end
      end
      jfp_pkg::ST_CSUM: begin
        if (is_space(c)) begin
        end else if (c == jfp_pkg::CH_STAR) begin
          p_state = jfp_pkg::ST_BASE;
        end else if (is_digit(c)) begin
          csum_acc = {csum_acc[jfp_pkg::CSUM_BITS-5:0], 4'(c - jfp_pkg::CH_ZERO)};
        end else if (u >= jfp_pkg::CH_A && u <= jfp_pkg::CH_F) begin
          csum_acc = {csum_acc[jfp_pkg::CSUM_BITS-5:0], 4'(u - jfp_pkg::CH_SEVEN)};
        end else begin
          halt_on(jfp_pkg::ERR_CSUM);
        end
      end
      jfp_pkg::ST_LADDR: begin
        if (is_digit(c)) begin
          n = decimal_step(64'(fuse_at), c);
          if (n > ADDR_MAX) halt_on(jfp_pkg::ERR_OVERFLOW);
          else fuse_at = n[jfp_pkg::FUSE_ADDR_BITS-1:0];
        end else if (is_space(c)) begin
          p_state = jfp_pkg::ST_LBITS;
        end else if (c == jfp_pkg::CH_STAR) begin
          p_state = jfp_pkg::ST_BASE;
        end else begin
          halt_on(jfp_pkg::ERR_LADDR);
        end
      end
      jfp_pkg::ST_LBITS: begin
        if (c == jfp_pkg::CH_STAR) begin
          p_state = jfp_pkg::ST_BASE;
        end else if (c == jfp_pkg::CH_ZERO || c == jfp_pkg::CH_ONE) begin
          if (fuse_at >= fuse_limit) begin
            halt_on(jfp_pkg::ERR_RANGE);
          end else begin
            r.fuse_write   = 1'b1;
            r.fuse_value   = c[0];
            r.fuse_address = fuse_at;
            fuse_at        = fuse_at + jfp_pkg::FUSE_ADDR_BITS'(1);
          end
        end else if (c == jfp_pkg::CH_SPACE || c == jfp_pkg::CH_LF ||
                     c == jfp_pkg::CH_CR) begin
        end else begin
          halt_on(jfp_pkg::ERR_FUSE);
        end
      end
      jfp_pkg::ST_Q: begin
        if (c == jfp_pkg::CH_F) begin
          if (fuse_limit != '0) halt_on(jfp_pkg::ERR_REPEAT);
          else p_state = jfp_pkg::ST_QF;
        end else if (c == jfp_pkg::CH_P) begin
          if (pin_limit != '0) halt_on(jfp_pkg::ERR_REPEAT);
          else p_state = jfp_pkg::ST_QP;
        end else begin
          p_state = jfp_pkg::ST_SKIP;
        end
      end
      jfp_pkg::ST_QF, jfp_pkg::ST_QP: begin
        if (is_space(c)) begin
        end else if (is_digit(c)) begin
          if (p_state == jfp_pkg::ST_QF) begin
            n = decimal_step(64'(fuse_limit), c);
            if (n > ADDR_MAX) halt_on(jfp_pkg::ERR_OVERFLOW);
            else fuse_limit = n[jfp_pkg::FUSE_ADDR_BITS-1:0];
          end else begin
            n = decimal_step(64'(pin_limit), c);
            if (n > PIN_MAX) halt_on(jfp_pkg::ERR_OVERFLOW);
            else pin_limit = n[jfp_pkg::PIN_BITS-1:0];
          end
        end else if (c == jfp_pkg::CH_STAR) begin
          p_state = jfp_pkg::ST_BASE;
        end else begin
          halt_on(jfp_pkg::ERR_COUNT);
        end
      end
      jfp_pkg::ST_SKIP: begin
        if (c == jfp_pkg::CH_STAR) p_state = jfp_pkg::ST_BASE;
      end
      default: p_state = jfp_pkg::ST_HALT;
    endcase
    r.fuse_total        = fuse_limit;
    r.pin_total         = pin_limit;
    r.declared_checksum = csum_acc;
    r.error_code        = err_seen;
    r.halted            = (p_state == jfp_pkg::ST_HALT);
    pending_results.push_back(r);
  endtask

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) src_quiet = !src_quiet;
    gap = src_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_byte(b);
    sent_count++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_number(input int unsigned v);
    send_text($sformatf("%0d", v));
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // bytes before the start character are ignored
  task automatic test_preamble();
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(jfp_pkg::CH_STAR);
    send_byte(jfp_pkg::CH_L);
    send_byte(jfp_pkg::CH_STX);
  endtask

  // zero counts may be repeated, then the largest fuse count and, when pins_used, pin count
  task automatic test_counts();
    send_text("QF0*QP0*");
    send_text("QF 1048575\t*");
    if (pins_used) send_text("QP65535*");
    send_text("QZ*");
  endtask

  task automatic test_fuse_runs();
    send_text("L0 1010*");
    send_text("L1048574\n1*");
    send_text("L007\r0 1\n\r0*");
    send_text("L9*");
  endtask

  task automatic test_checksum();
    send_text("CFFFF*");
    send_text("C 0\t000 *");
    send_byte(jfp_pkg::CH_C);
    send_byte(8'hc1);
    send_byte(8'he6);
    send_text("12345*");
    send_text("cabcdef*");
  endtask

  // skipped fields, star between fields, vertical tab and form feed
  task automatic test_skipped_fields();
    send_text("N DEV\tX*");
    send_byte(jfp_pkg::CH_SPACE);
    send_byte(CH_VT);
    send_byte(CH_FF);
    send_text("**G0*");
  endtask

  task automatic test_random_file();
    int unsigned start;
    int unsigned len;
    int unsigned addr;
    int unsigned i;
    bit          paused;
    logic [7:0]  b;
    start  = sent_count;
    paused = 1'b0;
    while (sent_count < start + RANDOM_BYTES) begin
      if (!paused && sent_count >= start + RANDOM_BYTES / 2) begin
        wait_results_drained();
        paused = 1'b1;
      end
      case ($urandom_range(0, 99)) inside
        [0:44]: begin
          len = $urandom_range(0, 24);
          case ($urandom_range(0, 2))
            0: addr = $urandom_range(0, 64);
            1: addr = $urandom_range(0, FUSE_TOP - len);
            default: addr = FUSE_TOP - len - $urandom_range(0, 8);
          endcase
          send_byte(jfp_pkg::CH_L);
          if ($urandom_range(0, 3) == 0) send_byte(jfp_pkg::CH_ZERO);
          send_number(addr);
          if (len == 0 && $urandom_range(0, 1) == 0) begin
            send_byte(jfp_pkg::CH_STAR);
          end else begin
            send_byte(rand_space());
            for (i = 0; i < len; i++) begin
              if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 2))
                  0: send_byte(jfp_pkg::CH_SPACE);
                  1: send_byte(jfp_pkg::CH_LF);
                  default: send_byte(jfp_pkg::CH_CR);
                endcase
              end
              send_byte($urandom_range(0, 1) ? jfp_pkg::CH_ONE : jfp_pkg::CH_ZERO);
            end
            send_byte(jfp_pkg::CH_STAR);
          end
        end
        [45:64]: begin
          send_byte(jfp_pkg::CH_C);
          len = $urandom_range(0, 6);
          for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 5) == 0) send_byte(rand_space());
            send_byte(hex_char());
          end
          send_byte(jfp_pkg::CH_STAR);
        end
        [65:79]: begin
          b = 8'($urandom_range(0, 255));
          while (is_space(b) || b == jfp_pkg::CH_L || b == jfp_pkg::CH_Q ||
                 b == jfp_pkg::CH_C)
            b = 8'($urandom_range(0, 255));
          send_byte(b);
          len = $urandom_range(0, 10);
          for (i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            while (b == jfp_pkg::CH_STAR) b = 8'($urandom_range(0, 255));
            send_byte(b);
          end
          send_byte(jfp_pkg::CH_STAR);
        end
        [80:87]: begin
          send_byte(jfp_pkg::CH_Q);
          b = 8'($urandom_range(0, 255));
          while (b == jfp_pkg::CH_F || b == jfp_pkg::CH_P) b = 8'($urandom_range(0, 255));
          send_byte(b);
          len = $urandom_range(0, 6);
          for (i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            while (b == jfp_pkg::CH_STAR) b = 8'($urandom_range(0, 255));
            send_byte(b);
          end
          send_byte(jfp_pkg::CH_STAR);
        end
        default: begin
          len = $urandom_range(1, 3);
          for (i = 0; i < len; i++) send_byte(rand_space());
        end
      endcase
    end
  endtask

  // one sticky error, then bytes that must all be ignored
  task automatic test_error_halt();
    int i;
    case (final_kind)
      END_LADDR_CHAR:    send_text("L12x");
      END_FUSE_CHAR:     send_text("L3 01\t");
      END_CSUM_CHAR:     send_text("C1G");
      END_COUNT_CHAR:    send_text("QP12#");
      END_REPEAT:        send_text("QF5");
      END_RANGE:         send_text("L1048575 1");
      END_ADDR_OVERFLOW: send_text("L1048576");
      default:           send_text("QP65536");
    endcase
    for (i = 0; i < 24; i++) send_byte(8'($urandom_range(0, 255)));
    send_text("\002QF1*L0 1*");
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_hold  <= 0;
    end else if (out_tvalid && out_tready) begin
      if ($urandom_range(0, 59) == 0) sink_quiet = !sink_quiet;
      sink_gap = sink_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (sink_gap != 0) begin
        out_tready <= 1'b0;
        sink_hold  <= sink_gap;
      end
    end else if (!out_tready) begin
      if (sink_hold <= 1) begin
        out_tready <= 1'b1;
        sink_hold  <= 0;
      end else begin
        sink_hold <= sink_hold - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("result %0d arrived with nothing expected", results_seen);
        mismatches++;
      end else begin
        automatic jfp_pkg::result_t want = pending_results.pop_front();
        if (out_tuser !== want.fuse_write || out_tdata[19:0] !== want.fuse_address ||
            out_tdata[20] !== want.fuse_value || out_tdata[40:21] !== want.fuse_total ||
            out_tdata[56:41] !== want.pin_total ||
            out_tdata[72:57] !== want.declared_checksum ||
            out_tdata[75:73] !== want.error_code || out_tdata[76] !== want.halted) begin
          if (mismatches < 10)
            $display({"result %0d: want wr %0d adr %h val %0d fc %h pc %h cs %h err %0d",
                      " halt %0d / got wr %0d adr %h val %0d fc %h pc %h cs %h err %0d",
                      " halt %0d"},
                     results_seen, want.fuse_write, want.fuse_address, want.fuse_value,
                     want.fuse_total, want.pin_total, want.declared_checksum,
                     want.error_code, want.halted, out_tuser, out_tdata[19:0],
                     out_tdata[20], out_tdata[40:21], out_tdata[56:41],
                     out_tdata[72:57], out_tdata[75:73], out_tdata[76]);
          mismatches++;
        end
      end
      results_seen++;
    end
  end

  initial begin
    final_kind = finale_t'($urandom_range(0, 7));
    pins_used  = !(final_kind == END_COUNT_CHAR || final_kind == END_PIN_OVERFLOW);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_preamble();
    test_counts();
    test_fuse_runs();
    test_checksum();
    test_skipped_fields();
    test_random_file();
    test_error_halt();
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("tb_jedec_fuse_file_parser_unit passed");
    else
      $display("tb_jedec_fuse_file_parser_unit failed");
    $finish;
  end

endmodule
